// File: sv/sorted_stream_id_table_macros.svh
// Assertion helpers used by the table datapath.
`ifndef SORTED_STREAM_ID_TABLE_MACROS_SVH
`define SORTED_STREAM_ID_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sst assertion failed");

// Next-cycle implication, checked outside reset.
`define SST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sst assertion failed");

`endif

// File: sv/sst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and codes for the sorted stream id table.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam int unsigned IdW     = 32;
  localparam int unsigned HandleW = 16;
  localparam int unsigned EntryW  = IdW + HandleW;
  localparam int unsigned CountW  = 7;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ADD_RD,
    OP_ADD_MOVE,
    OP_ADD_PUT,
    OP_MAX_RD,
    OP_MAX_SET,
    OP_MAX_CLR,
    OP_RD_PTR,
    OP_PTR_INC,
    OP_RD_NEXT,
    OP_SH_WRITE,
    OP_REM_DONE,
    OP_RD_MID,
    OP_LK_NARROW,
    OP_LK_HIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       res_en;
    logic [1:0] res_code;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       ptr_zero;
    logic       ptr_at_end;
    logic       sh_last;
    logic       rd_gt;
    logic       rd_eq;
    logic       id_above;
    logic       id_is_max;
    logic       id_neg;
    logic       cnt_gt1;
    logic       cnt_zero;
    logic       lo_ge_hi;
    logic       out_busy;
  } dp_stat_t;

endpackage

// File: sv/sst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// File: sv/sst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_ctrl
// Command sequencer: walks add, remove and lookup through the datapath.
// ----------------------------------------------------------------------------
module sst_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sst_pkg::dp_stat_t stat_i,
  output sst_pkg::dp_cmd_t  cmd_o
);
  import sst_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_DEC     = 12'b000000000010,
    S_ADD_RD  = 12'b000000000100,
    S_ADD_CHK = 12'b000000001000,
    S_MAX_W   = 12'b000000010000,
    S_REM_RD  = 12'b000000100000,
    S_REM_CHK = 12'b000001000000,
    S_SH_RD   = 12'b000010000000,
    S_SH_WR   = 12'b000100000000,
    S_LK_RD   = 12'b001000000000,
    S_LK_CHK  = 12'b010000000000,
    S_RESP    = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o.op       = OP_NONE;
    cmd_o.res_en   = 1'b0;
    cmd_o.res_code = ST_MISS;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        priority if (stat_i.cmd == CMD_ADD) begin
          if (stat_i.full) begin
            cmd_o.res_en   = 1'b1;
            cmd_o.res_code = ST_FULL;
            state_d        = S_RESP;
          end else begin
            state_d = S_ADD_RD;
          end
        end else if (stat_i.cmd == CMD_REMOVE) begin
          priority if (stat_i.id_above) begin
            cmd_o.res_en = 1'b1;
            state_d      = S_RESP;
          end else if (stat_i.id_is_max && stat_i.cnt_gt1) begin
            cmd_o.op = OP_MAX_RD;
            state_d  = S_MAX_W;
          end else if (stat_i.id_is_max) begin
            cmd_o.op = OP_MAX_CLR;
            state_d  = S_REM_RD;
          end else begin
            state_d = S_REM_RD;
          end
        end else if (stat_i.cmd == CMD_LOOKUP) begin
          if (stat_i.id_neg || stat_i.id_above || stat_i.cnt_zero) begin
            cmd_o.res_en = 1'b1;
            state_d      = S_RESP;
          end else begin
            state_d = S_LK_RD;
          end
        end else begin
          cmd_o.res_en = 1'b1;
          state_d      = S_RESP;
        end
      end
      S_ADD_RD: begin
        if (stat_i.ptr_zero) begin
          cmd_o.op = OP_ADD_PUT;
          state_d  = S_RESP;
        end else begin
          cmd_o.op = OP_ADD_RD;
          state_d  = S_ADD_CHK;
        end
      end
      S_ADD_CHK: begin
        if (stat_i.rd_gt) begin
          cmd_o.op = OP_ADD_MOVE;
          state_d  = S_ADD_RD;
        end else begin
          cmd_o.op = OP_ADD_PUT;
          state_d  = S_RESP;
        end
      end
      S_MAX_W: begin
        cmd_o.op = OP_MAX_SET;
        state_d  = S_REM_RD;
      end
      S_REM_RD: begin
        if (stat_i.ptr_at_end) begin
          cmd_o.res_en = 1'b1;
          state_d      = S_RESP;
        end else begin
          cmd_o.op = OP_RD_PTR;
          state_d  = S_REM_CHK;
        end
      end
      S_REM_CHK: begin
        if (stat_i.rd_eq) begin
          state_d = S_SH_RD;
        end else begin
          cmd_o.op = OP_PTR_INC;
          state_d  = S_REM_RD;
        end
      end
      S_SH_RD: begin
        if (stat_i.sh_last) begin
          cmd_o.op = OP_REM_DONE;
          state_d  = S_RESP;
        end else begin
          cmd_o.op = OP_RD_NEXT;
          state_d  = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd_o.op = OP_SH_WRITE;
        state_d  = S_SH_RD;
      end
      S_LK_RD: begin
        cmd_o.op = OP_RD_MID;
        state_d  = S_LK_CHK;
      end
      S_LK_CHK: begin
        priority if (stat_i.rd_eq) begin
          cmd_o.op = OP_LK_HIT;
          state_d  = S_RESP;
        end else if (stat_i.lo_ge_hi) begin
          cmd_o.res_en = 1'b1;
          state_d      = S_RESP;
        end else begin
          cmd_o.op = OP_LK_NARROW;
          state_d  = S_LK_RD;
        end
      end
      S_RESP: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/sst_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_datapath
// Table storage, pointers, compare logic and the output register.
// ----------------------------------------------------------------------------
`include "sorted_stream_id_table_macros.svh"

module sst_datapath #(
  parameter int unsigned Depth = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [1:0]                           in_cmd_i,
  input  logic signed [sst_pkg::IdW-1:0]       in_id_i,
  input  logic [sst_pkg::HandleW-1:0]          in_handle_i,
  input  sst_pkg::dp_cmd_t                     cmd_i,
  output sst_pkg::dp_stat_t                    stat_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           out_status_o,
  output logic [sst_pkg::HandleW-1:0]          out_handle_o,
  output logic [sst_pkg::CountW-1:0]           out_count_o
);
  import sst_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = AW + 1;

  logic [1:0]               cmd_q;
  logic signed [IdW-1:0]    id_q, largest_q;
  logic [HandleW-1:0]       handle_q, found_q;
  logic [CW-1:0]            count_q, ptr_q;
  logic [AW-1:0]            lo_q, hi_q;
  logic [1:0]               res_q;
  logic                     out_valid_q;

  logic                     wr_en, rd_en;
  logic [AW-1:0]            wr_addr, rd_addr;
  logic [EntryW-1:0]        wr_data, rd_data;
  logic signed [IdW-1:0]    rd_id;
  logic [HandleW-1:0]       rd_handle;
  logic [AW:0]              mid_sum;
  logic [AW-1:0]            mid;

  assign rd_id     = rd_data[IdW-1:0];
  assign rd_handle = rd_data[EntryW-1:IdW];
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid       = mid_sum[AW:1];

  sst_ram #(
    .Width (EntryW),
    .Depth (Depth)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // memory port steering
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_q[AW-1:0];
    wr_data = rd_data;
    rd_en   = 1'b1;
    rd_addr = ptr_q[AW-1:0];
    unique case (cmd_i.op)
      OP_ADD_RD:   rd_addr = AW'(ptr_q - CW'(1));
      OP_MAX_RD:   rd_addr = AW'(count_q - CW'(2));
      OP_RD_NEXT:  rd_addr = AW'(ptr_q + CW'(1));
      OP_RD_MID:   rd_addr = mid;
      OP_ADD_MOVE: wr_en   = 1'b1;
      OP_SH_WRITE: wr_en   = 1'b1;
      OP_ADD_PUT: begin
        wr_en   = 1'b1;
        wr_data = {handle_q, id_q};
      end
      default: rd_en = (cmd_i.op == OP_RD_PTR);
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        cmd_q    <= in_cmd_i;
        id_q     <= in_id_i;
        handle_q <= in_handle_i;
        found_q  <= '0;
        ptr_q    <= (in_cmd_i == CMD_ADD) ? count_q : '0;
        lo_q     <= '0;
        hi_q     <= AW'(count_q - CW'(1));
      end
      OP_ADD_MOVE: ptr_q <= ptr_q - CW'(1);
      OP_ADD_PUT:  res_q <= ST_OK;
      OP_PTR_INC:  ptr_q <= ptr_q + CW'(1);
      OP_SH_WRITE: ptr_q <= ptr_q + CW'(1);
      OP_REM_DONE: res_q <= ST_OK;
      OP_RD_MID:   ptr_q <= CW'(mid);
      OP_LK_NARROW: begin
        if (rd_id < id_q) begin
          lo_q <= AW'(ptr_q + CW'(1));
        end else begin
          hi_q <= ptr_q[AW-1:0];
        end
      end
      OP_LK_HIT: begin
        res_q   <= ST_OK;
        found_q <= rd_handle;
      end
      default: ;
    endcase
    if (cmd_i.res_en) begin
      res_q <= cmd_i.res_code;
    end
    if (cmd_i.out_load) begin
      out_status_o <= res_q;
      out_handle_o <= found_q;
      out_count_o  <= CountW'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      largest_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.out_load || (out_valid_q && !out_ready_i);
      unique case (cmd_i.op)
        OP_ADD_PUT: begin
          count_q <= count_q + CW'(1);
          if (id_q > largest_q) begin
            largest_q <= id_q;
          end
        end
        OP_REM_DONE: count_q   <= count_q - CW'(1);
        OP_MAX_SET:  largest_q <= rd_id;
        OP_MAX_CLR: begin
          if (count_q == CW'(1)) begin
            largest_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    stat_o.cmd        = cmd_q;
    stat_o.full       = (count_q >= CW'(Depth));
    stat_o.ptr_zero   = (ptr_q == '0);
    stat_o.ptr_at_end = (ptr_q >= count_q);
    stat_o.sh_last    = ((ptr_q + CW'(1)) >= count_q);
    stat_o.rd_gt      = (rd_id > id_q);
    stat_o.rd_eq      = (rd_id == id_q);
    stat_o.id_above   = (id_q > largest_q);
    stat_o.id_is_max  = (id_q == largest_q);
    stat_o.id_neg     = id_q[IdW-1];
    stat_o.cnt_gt1    = (count_q > CW'(1));
    stat_o.cnt_zero   = (count_q == '0);
    stat_o.lo_ge_hi   = (lo_q >= hi_q);
    stat_o.out_busy   = out_valid_q && !out_ready_i;
  end

  `SST_ASSERT_SAME(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(Depth))
  `SST_ASSERT_SAME(a_put_not_full, clk_i, rst_ni, cmd_i.op == OP_ADD_PUT, count_q < CW'(Depth))
  `SST_ASSERT_SAME(a_drop_not_empty, clk_i, rst_ni, cmd_i.op == OP_REM_DONE, count_q != '0)
  `SST_ASSERT_NEXT(a_out_follows_load, clk_i, rst_ni, cmd_i.out_load, out_valid_q)

endmodule

// File: sv/sorted_stream_id_table.sv
`timescale 1ns / 1ps
// Rejects and full answers skip the entry RAM; add moves entries up one slot until
// the new id fits, remove scans to the entry and shifts the rest down, lookup probes.
// Commands are taken one at a time; each walks the entry RAM one entry at a time
// through its single write port and single read port.
// Reset: rst_ni clears the entry count, the largest id and the output valid;
// the RAM is not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
// sorted_stream_id_table
// Table of stream id / buffer handle pairs kept sorted by signed id, with
// add, remove and binary-search lookup commands and one result per command.
// ----------------------------------------------------------------------------
module sorted_stream_id_table #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] cmd, [33:2] stream_id, [49:34] buffer_handle, rest zero
  input  logic [55:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] status, [17:2] found_handle, [24:18] entry_count, rest zero
  output logic [31:0] m_axis_tdata_o
);
  import sst_pkg::*;

  dp_cmd_t             dp_cmd;
  dp_stat_t            dp_stat;
  logic [1:0]          out_status;
  logic [HandleW-1:0]  out_handle;
  logic [CountW-1:0]   out_count;

  // The controller accepts a beat only when idle; the result register sits in
  // the datapath, so a new beat may be taken while the previous result waits.
  sst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  sst_datapath #(
    .Depth (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_cmd_i     (s_axis_tdata_i[1:0]),
    .in_id_i      (s_axis_tdata_i[33:2]),
    .in_handle_i  (s_axis_tdata_i[49:34]),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (out_status),
    .out_handle_o (out_handle),
    .out_count_o  (out_count)
  );

  // Pack the result beat, lowest field first.
  assign m_axis_tdata_o = {7'd0, out_count, out_handle, out_status};

endmodule
